[rtl/twag_pkg.sv]
package twag_pkg;

  // ring geometry
  localparam int DEPTH  = 128;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int LEVEL_W = 15;
  localparam int STAMP_W = 32;
  localparam int SPAN_W  = 10;
  localparam int USED_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // full scale, one hundred percent in 1/256 percent units
  localparam int LEVEL_FULL = 25600;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVEL_FULL);

  // reset values of the registers
  localparam logic [STAMP_W-1:0] WINDOW_RESET = STAMP_W'(60000);
  localparam logic [SPAN_W-1:0]  SPAN_RESET   = SPAN_W'(158);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FILL_SPAN = CFG_IDX_W'(1);

  // datapath widths
  localparam int SUM_W  = $clog2(DEPTH * LEVEL_FULL + 1);
  localparam int PROD_W = SPAN_W + LEVEL_W;
  localparam int DIVD_W = SUM_W;
  localparam int DIVS_W = CNT_W;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  // bar fill divide by 25600 = 1024 * 25: shift by 10, then multiply by
  // ceil(2^20 / 25) and shift by 20, exact for shifted products below 43690
  localparam int FILL_PRE_SHIFT   = 10;
  localparam int FILL_PRE_W       = PROD_W - FILL_PRE_SHIFT;
  localparam int FILL_RECIP_W     = 16;
  localparam logic [FILL_RECIP_W-1:0] FILL_RECIP = FILL_RECIP_W'(41944);
  localparam int FILL_RECIP_SHIFT = 20;
  localparam int FILL_Q_W         = FILL_PRE_W + FILL_RECIP_W;
  localparam int FILL_HI_W        = FILL_Q_W - FILL_RECIP_SHIFT;

  // one ring entry
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [LEVEL_W-1:0] sample;
  } entry_t;

  // ring write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } ring_wr_t;

  // divider start request
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

endpackage

[rtl/twag_in_if.sv]
interface twag_in_if;
  import twag_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_sample;
  logic [STAMP_W-1:0] now_ms;

  modport source (output valid, output level_sample, output now_ms, input ready);
  modport sink (input valid, input level_sample, input now_ms, output ready);
endinterface

[rtl/twag_out_if.sv]
interface twag_out_if;
  import twag_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] average_level;
  logic [USED_W-1:0]  samples_used;
  logic [SPAN_W-1:0]  fill_width;

  modport source (output valid, output average_level, output samples_used,
                  output fill_width, input ready);
  modport sink (input valid, input average_level, input samples_used,
                input fill_width, output ready);
endinterface

[rtl/twag_cfg_if.sv]
interface twag_cfg_if;
  import twag_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/twag_ring.sv]
module twag_ring (
  input  logic                           clk,
  input  twag_pkg::ring_wr_t             wr,
  input  logic                           rd_en,
  input  logic [twag_pkg::ADDR_W-1:0]    rd_addr,
  output twag_pkg::entry_t               rd_data
);
  import twag_pkg::*;

  entry_t mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // one read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/twag_div.sv]
module twag_div (
  input  logic                         clk,
  input  logic                         rst,
  input  twag_pkg::div_req_t           req,
  output logic                         done,
  output logic [twag_pkg::DIVD_W-1:0]  quotient
);
  import twag_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVD_W-1:0]    quo;
  logic [DIVS_W-1:0]    rem;
  logic [DIVS_W-1:0]    dvs;
  logic [DIVS_W:0]      shifted;
  logic [DIVS_W:0]      diff;
  logic                 fits;

  // one restoring step: shift in next dividend bit, try subtract
  always_comb begin
    shifted = {rem, quo[DIVD_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = (shifted >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIVD_W-2:0], fits};
      rem <= fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

[rtl/time_window_average_gauge.sv]
// channel     | dir | payload                                       | handshake
// ------------+-----+-----------------------------------------------+------------
// sample_in   | in  | level_sample[14:0], now_ms[31:0]              | valid/ready
// result_out  | out | average_level[14:0], samples_used[7:0],       | valid/ready
//             |     | fill_width[9:0]                               |
// cfg         | in  | index[0:0] (0 window_ms, 1 fill_span), data   | valid/ready
//
// one request walks the valid ring entries from newest to oldest in ST_WALK;
// the walk reads one ring entry per cycle through the single ring read port, then
// the serial divider forms the average and ST_MUL, ST_RECIP, ST_FILL the bar fill
// rst is synchronous: registers back to defaults, ring empty, no clearing pass
// a waiting result does not block the next request, whose result holds in ST_DONE
// cfg is ready outside reset and is meant to be written between requests
module time_window_average_gauge (
  input logic        clk,
  input logic        rst,
  twag_in_if.sink    sample_in,
  twag_out_if.source result_out,
  twag_cfg_if.sink   cfg
);
  import twag_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_WALK       = 9'b000000010,
    ST_DRAIN      = 9'b000000100,
    ST_AVG_START  = 9'b000001000,
    ST_AVG_WAIT   = 9'b000010000,
    ST_MUL        = 9'b000100000,
    ST_RECIP      = 9'b001000000,
    ST_FILL       = 9'b010000000,
    ST_DONE       = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [STAMP_W-1:0]  window_ms;
  logic [SPAN_W-1:0]   fill_span;
  logic [ADDR_W-1:0]   write_slot;
  logic [CNT_W-1:0]    valid_entries;
  logic [ADDR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]    rd_cnt;
  logic                rd_pending;
  logic [STAMP_W-1:0]  now_reg;
  logic [LEVEL_W-1:0]  level_reg;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    used;
  logic [LEVEL_W-1:0]  avg;
  logic [PROD_W-1:0]   prod;
  logic [FILL_Q_W-1:0] recip_prod;
  logic [FILL_HI_W-1:0] fill_q;
  logic [SPAN_W-1:0]   fill;
  logic [LEVEL_W-1:0]  level_sat;
  logic [STAMP_W-1:0]  age;
  logic                in_acc;
  logic                cfg_acc;
  logic                out_load;
  logic                rd_en;
  ring_wr_t            ring_wr;
  entry_t              rd_data;
  div_req_t            div_req;
  logic                div_done;
  logic [DIVD_W-1:0]   div_quo;
  logic                out_valid;
  logic [LEVEL_W-1:0]  out_avg;
  logic [USED_W-1:0]   out_used;
  logic [SPAN_W-1:0]   out_fill;

  // handshakes
  assign sample_in.ready = (state == ST_IDLE) && !rst;
  assign in_acc  = sample_in.valid && sample_in.ready;
  assign cfg.ready = !rst;
  assign cfg_acc = cfg.valid && cfg.ready;
  assign out_load = (state == ST_DONE) && (!out_valid || result_out.ready);

  // saturate the incoming sample
  assign level_sat = (sample_in.level_sample > LEVEL_MAX) ? LEVEL_MAX : sample_in.level_sample;

  // ring write on accept
  always_comb begin
    ring_wr.en          = in_acc;
    ring_wr.addr        = write_slot;
    ring_wr.data.stamp  = sample_in.now_ms;
    ring_wr.data.sample = level_sat;
  end

  assign rd_en = (state == ST_WALK);

  twag_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  // divider feed: sum over count
  always_comb begin
    div_req.start    = (state == ST_AVG_START);
    div_req.dividend = DIVD_W'(sum);
    div_req.divisor  = DIVS_W'(used);
  end

  twag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_acc) state_next = ST_WALK;
      ST_WALK:       if (rd_cnt == valid_entries - CNT_W'(1)) state_next = ST_DRAIN;
      ST_DRAIN:      state_next = ST_AVG_START;
      ST_AVG_START:  state_next = ST_AVG_WAIT;
      ST_AVG_WAIT:   if (div_done) state_next = ST_MUL;
      ST_MUL:        state_next = ST_RECIP;
      ST_RECIP:      state_next = ST_FILL;
      ST_FILL:       state_next = ST_DONE;
      ST_DONE:       if (out_load) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_RESET;
      fill_span <= SPAN_RESET;
    end else if (cfg_acc) begin
      case (cfg.index)
        REG_WINDOW_MS: window_ms <= cfg.data[STAMP_W-1:0];
        REG_FILL_SPAN: fill_span <= cfg.data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // ring pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      valid_entries <= '0;
      rd_pending    <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      if (in_acc) begin
        write_slot <= (write_slot == ADDR_W'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
        if (valid_entries < CNT_W'(DEPTH)) begin
          valid_entries <= valid_entries + 1'b1;
        end
      end
    end
  end

  // walk newest to oldest, one entry per cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_ptr    <= write_slot;
      rd_cnt    <= '0;
      now_reg   <= sample_in.now_ms;
      level_reg <= level_sat;
    end else if (rd_en) begin
      rd_ptr <= (rd_ptr == '0) ? ADDR_W'(DEPTH - 1) : rd_ptr - 1'b1;
      rd_cnt <= rd_cnt + 1'b1;
    end
  end

  // age check and accumulate on returned ring data
  assign age = now_reg - rd_data.stamp;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sum  <= '0;
      used <= '0;
    end else if (rd_pending && (age <= window_ms)) begin
      sum  <= sum + SUM_W'(rd_data.sample);
      used <= used + 1'b1;
    end
  end

  // high bits of the reciprocal product give the bar fill quotient
  assign fill_q = recip_prod[FILL_Q_W-1:FILL_RECIP_SHIFT];

  // average, product and bar fill
  always_ff @(posedge clk) begin
    if (state == ST_AVG_WAIT && div_done) begin
      if (used == '0) begin
        avg <= level_reg;
      end else if (div_quo > DIVD_W'(LEVEL_FULL)) begin
        avg <= LEVEL_MAX;
      end else begin
        avg <= div_quo[LEVEL_W-1:0];
      end
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(fill_span) * PROD_W'(avg);
    end
    if (state == ST_RECIP) begin
      recip_prod <= FILL_Q_W'(prod[PROD_W-1:FILL_PRE_SHIFT]) * FILL_Q_W'(FILL_RECIP);
    end
    if (state == ST_FILL) begin
      fill <= (fill_q > FILL_HI_W'(fill_span)) ? fill_span : fill_q[SPAN_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_avg  <= avg;
      out_used <= USED_W'(used);
      out_fill <= fill;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.average_level = out_avg;
  assign result_out.samples_used  = out_used;
  assign result_out.fill_width    = out_fill;

  // checks
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_WALK)
    else $error("accepted request did not start the walk");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> rd_cnt < valid_entries)
    else $error("walk read past the valid entries");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> (used <= valid_entries) && (used != '0))
    else $error("sample count out of range");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_AVG_WAIT)
    else $error("divider finished outside the wait state");

endmodule
